>>> sv/kntbl_pkg.sv
package kntbl_pkg;

  localparam int DefDepth = 64;

  // operation codes
  localparam logic [3:0] OP_CLEAR  = 4'd0;
  localparam logic [3:0] OP_LOOKUP = 4'd1;
  localparam logic [3:0] OP_INSERT = 4'd2;
  localparam logic [3:0] OP_AUTO   = 4'd3;
  localparam logic [3:0] OP_REMOVE = 4'd4;
  localparam logic [3:0] OP_CHID   = 4'd5;
  localparam logic [3:0] OP_CHTYPE = 4'd6;
  localparam logic [3:0] OP_CHEXT  = 4'd7;
  localparam logic [3:0] OP_CHPOS  = 4'd8;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_NOFREE   = 3'd4;

  localparam logic [15:0] MaxId = 16'hFFFF;

  // one table entry
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] ty;
    logic [15:0] ext;
    logic [31:0] x;
    logic [31:0] y;
  } node_t;

  localparam int NodeW = $bits(node_t);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic scan;
    logic act;
    logic shift;
    logic box;
    logic box_start;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ptr_end;
    logic rv;
    logic shift_go;
  } sts_t;

endpackage

>>> sv/kntbl_ram.sv
module kntbl_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/kntbl_ctrl.sv
module kntbl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kntbl_pkg::cmd_t    cmd_o,
  input  kntbl_pkg::sts_t    sts_i
);
  import kntbl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACT, S_SHIFT, S_BOX, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        cmd_o.rd   = !sts_i.ptr_end;
        if (sts_i.ptr_end && !sts_i.rv) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        cmd_o.act = 1'b1;
        state_d   = sts_i.shift_go ? S_SHIFT : S_BOX;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        cmd_o.rd    = !sts_i.ptr_end;
        if (sts_i.ptr_end && !sts_i.rv) begin
          cmd_o.box_start = 1'b1;
          state_d         = S_BOX;
        end
      end
      S_BOX: begin
        cmd_o.box = 1'b1;
        cmd_o.rd  = !sts_i.ptr_end;
        if (sts_i.ptr_end && !sts_i.rv) begin
          out_valid_d = 1'b1;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> sv/kntbl_dp.sv
module kntbl_dp #(
  parameter int TABLE_DEPTH = kntbl_pkg::DefDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kntbl_pkg::cmd_t     cmd_i,
  output kntbl_pkg::sts_t     sts_o,
  input  logic [3:0]          operation_i,
  input  logic [15:0]         node_id_i,
  input  logic [15:0]         new_id_i,
  input  logic [15:0]         node_type_i,
  input  logic signed [15:0]  ext_type_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  output logic [2:0]          status_o,
  output logic [15:0]         result_id_o,
  output logic [15:0]         result_type_o,
  output logic signed [15:0]  result_ext_type_o,
  output logic signed [31:0]  result_x_o,
  output logic signed [31:0]  result_y_o,
  output logic signed [31:0]  min_x_o,
  output logic signed [31:0]  max_x_o,
  output logic signed [31:0]  min_y_o,
  output logic signed [31:0]  max_y_o,
  output logic [6:0]          entry_count_o
);
  import kntbl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // operand registers
  logic [3:0]  op_q;
  logic [15:0] id_q, nid_q, ty_q, ext_q;
  logic [31:0] x_q, y_q;

  logic [CW-1:0] cnt_q, ptr_q, ridx_q;
  logic          rv_q;
  logic          hit_q, nhit_q;
  logic [AW-1:0] k_q;
  logic [15:0]   top_q;
  node_t         node_q;
  logic          bb_any_q;
  logic [31:0]   lx_q, hx_q, ly_q, hy_q;
  logic [2:0]    status_q;
  node_t         res_q;

  node_t         rdata;
  logic          we;
  logic [AW-1:0] waddr;
  node_t         wdata;
  logic [CW-1:0] sh_idx;

  // act decision
  logic [2:0]    act_st;
  node_t         act_node;
  logic          act_we;
  logic [AW-1:0] act_addr;
  logic          act_inc, act_clr, shift_go;
  logic          full;
  logic [15:0]   top_inc;

  kntbl_ram #(.Width(NodeW), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(ptr_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign full    = (cnt_q == CW'(TABLE_DEPTH));
  assign top_inc = top_q + 16'd1;

  // operation outcome after the search pass
  always_comb begin
    act_st   = ST_OK;
    act_node = '0;
    act_we   = 1'b0;
    act_addr = k_q;
    act_inc  = 1'b0;
    act_clr  = 1'b0;
    shift_go = 1'b0;
    case (op_q)
      OP_CLEAR: act_clr = 1'b1;
      OP_INSERT: begin
        if (hit_q) begin
          act_st = ST_DUP;
        end else if (full) begin
          act_st = ST_FULL;
        end else begin
          act_node = '{id: id_q, ty: ty_q, ext: ext_q, x: x_q, y: y_q};
          act_we   = 1'b1;
          act_addr = cnt_q[AW-1:0];
          act_inc  = 1'b1;
        end
      end
      OP_AUTO: begin
        if (top_q == MaxId) begin
          act_st = ST_NOFREE;
        end else if (full) begin
          act_st = ST_FULL;
        end else begin
          act_node = '{id: top_inc, ty: 16'd0, ext: 16'd0, x: x_q, y: y_q};
          act_we   = 1'b1;
          act_addr = cnt_q[AW-1:0];
          act_inc  = 1'b1;
        end
      end
      OP_LOOKUP, OP_REMOVE, OP_CHID, OP_CHTYPE, OP_CHEXT, OP_CHPOS: begin
        if (!hit_q) begin
          act_st = ST_NOTFOUND;
        end else if (op_q == OP_CHID && nhit_q) begin
          act_st = ST_DUP;
        end else begin
          act_node = node_q;
          case (op_q)
            OP_REMOVE: shift_go = 1'b1;
            OP_CHID:   begin act_node.id  = nid_q; act_we = 1'b1; end
            OP_CHTYPE: begin act_node.ty  = ty_q;  act_we = 1'b1; end
            OP_CHEXT:  begin act_node.ext = ext_q; act_we = 1'b1; end
            OP_CHPOS:  begin
              act_node.x = x_q;
              act_node.y = y_q;
              act_we     = 1'b1;
            end
            default: act_we = 1'b0;
          endcase
        end
      end
      default: act_st = ST_OK;
    endcase
  end

  // ram write port: act write or compaction step
  assign sh_idx = ridx_q - CW'(1);
  always_comb begin
    if (cmd_i.shift) begin
      we    = rv_q;
      waddr = sh_idx[AW-1:0];
      wdata = rdata;
    end else begin
      we    = cmd_i.act && act_we;
      waddr = act_addr;
      wdata = act_node;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      rv_q <= cmd_i.rd;
      if (cmd_i.rd) begin
        ptr_q <= ptr_q + CW'(1);
      end
      if (cmd_i.load || cmd_i.box_start) begin
        ptr_q <= '0;
      end
      if (cmd_i.act) begin
        ptr_q <= shift_go ? CW'(k_q) + CW'(1) : '0;
        if (act_clr) begin
          cnt_q <= '0;
        end else if (act_inc) begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.box_start) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // operands, search and bounding-box accumulators, result
  always_ff @(posedge clk_i) begin
    ridx_q <= ptr_q;
    if (cmd_i.load) begin
      op_q   <= operation_i;
      id_q   <= node_id_i;
      nid_q  <= new_id_i;
      ty_q   <= node_type_i;
      ext_q  <= ext_type_i;
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      hit_q  <= 1'b0;
      nhit_q <= 1'b0;
      top_q  <= '0;
      k_q    <= '0;
      node_q <= '0;
    end
    if (cmd_i.scan && rv_q) begin
      if (!hit_q && rdata.id == id_q) begin
        hit_q  <= 1'b1;
        k_q    <= ridx_q[AW-1:0];
        node_q <= rdata;
      end
      if (rdata.id == nid_q) begin
        nhit_q <= 1'b1;
      end
      if (rdata.id > top_q) begin
        top_q <= rdata.id;
      end
    end
    if (cmd_i.act) begin
      status_q <= act_st;
      res_q    <= act_node;
    end
    if (cmd_i.act || cmd_i.box_start) begin
      bb_any_q <= 1'b0;
      lx_q     <= '0;
      hx_q     <= '0;
      ly_q     <= '0;
      hy_q     <= '0;
    end
    if (cmd_i.box && rv_q) begin
      bb_any_q <= 1'b1;
      if (!bb_any_q || $signed(rdata.x) < $signed(lx_q)) lx_q <= rdata.x;
      if (!bb_any_q || $signed(rdata.x) > $signed(hx_q)) hx_q <= rdata.x;
      if (!bb_any_q || $signed(rdata.y) < $signed(ly_q)) ly_q <= rdata.y;
      if (!bb_any_q || $signed(rdata.y) > $signed(hy_q)) hy_q <= rdata.y;
    end
  end

  assign sts_o.ptr_end  = (ptr_q >= cnt_q);
  assign sts_o.rv       = rv_q;
  assign sts_o.shift_go = shift_go;

  // result ports
  logic [CW+6:0] cnt_wide;
  assign cnt_wide          = {7'd0, cnt_q};
  assign entry_count_o     = cnt_wide[6:0];
  assign status_o          = status_q;
  assign result_id_o       = res_q.id;
  assign result_type_o     = res_q.ty;
  assign result_ext_type_o = res_q.ext;
  assign result_x_o        = res_q.x;
  assign result_y_o        = res_q.y;
  assign min_x_o           = lx_q;
  assign max_x_o           = hx_q;
  assign min_y_o           = ly_q;
  assign max_y_o           = hy_q;

endmodule

>>> sv/keyed_node_table_top.sv
// one item at a time: search pass over all n entries, an action step, then a
// bounding-box pass over the entries (n = count)
// remove adds a compaction pass over the entries after the match at index k
// each pass streams one entry a cycle through the single ram read port
// result is held until taken; next item is accepted after the result leaves
// rst_ni (async, active low) clears the count and control; table ram is not cleared
module keyed_node_table_top #(
  parameter int TABLE_DEPTH = kntbl_pkg::DefDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         operation_i,
  input  logic [15:0]        node_id_i,
  input  logic [15:0]        new_id_i,
  input  logic [15:0]        node_type_i,
  input  logic signed [15:0] ext_type_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [15:0]        result_id_o,
  output logic [15:0]        result_type_o,
  output logic signed [15:0] result_ext_type_o,
  output logic signed [31:0] result_x_o,
  output logic signed [31:0] result_y_o,
  output logic signed [31:0] min_x_o,
  output logic signed [31:0] max_x_o,
  output logic signed [31:0] min_y_o,
  output logic signed [31:0] max_y_o,
  output logic [6:0]         entry_count_o
);
  import kntbl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kntbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  kntbl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (operation_i),
    .node_id_i        (node_id_i),
    .new_id_i         (new_id_i),
    .node_type_i      (node_type_i),
    .ext_type_i       (ext_type_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .status_o         (status_o),
    .result_id_o      (result_id_o),
    .result_type_o    (result_type_o),
    .result_ext_type_o(result_ext_type_o),
    .result_x_o       (result_x_o),
    .result_y_o       (result_y_o),
    .min_x_o          (min_x_o),
    .max_x_o          (max_x_o),
    .min_y_o          (min_y_o),
    .max_y_o          (max_y_o),
    .entry_count_o    (entry_count_o)
  );

  // a pending result keeps the input side closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // errors carry no node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (result_id_o == 16'd0 && result_x_o == 32'sd0))
    else $error("node fields set on error");

  // empty table gives an empty box
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_count_o == 7'd0 && TABLE_DEPTH < 128)
      |-> (min_x_o == 32'sd0 && max_y_o == 32'sd0))
    else $error("box not zero on empty table");

  // a single action step between the search and the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.act |=> !cmd.act)
    else $error("double action");

endmodule

>>> tb/keyed_node_table_top_test.sv
module keyed_node_table_top_test;
  import kntbl_pkg::*;

  localparam int Depth = DefDepth;
  localparam int CycleLimit = 2000000;
  localparam int DrainCycles = 400;

  // one accepted result
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] rid;
    logic [15:0] rty;
    logic [15:0] rext;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] lx;
    logic [31:0] hx;
    logic [31:0] ly;
    logic [31:0] hy;
    logic [6:0]  cnt;
  } node_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [3:0]         operation_i;
  logic [15:0]        node_id_i;
  logic [15:0]        new_id_i;
  logic [15:0]        node_type_i;
  logic signed [15:0] ext_type_i;
  logic signed [31:0] pos_x_i;
  logic signed [31:0] pos_y_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         status_o;
  logic [15:0]        result_id_o;
  logic [15:0]        result_type_o;
  logic signed [15:0] result_ext_type_o;
  logic signed [31:0] result_x_o;
  logic signed [31:0] result_y_o;
  logic signed [31:0] min_x_o;
  logic signed [31:0] max_x_o;
  logic signed [31:0] min_y_o;
  logic signed [31:0] max_y_o;
  logic [6:0]         entry_count_o;

  keyed_node_table_top uut (.*);

  // shadow copy of the table
  node_t        shadow_nodes[Depth];
  int           shadow_count;
  node_result_t pending_results[$];
  int           error_count;
  int           cycle_count;
  int           burst_left;
  bit           hold_off;
  int           hold_cycles;

  // clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // compute the result of one operation and update the shadow table
  function automatic node_result_t apply_node_op(logic [3:0] op, logic [15:0] id,
      logic [15:0] nid, logic [15:0] ty, logic [15:0] ext, logic [31:0] px,
      logic [31:0] py);
    node_result_t r;
    int k;
    int hit;
    logic [16:0] top;
    r = '0;
    r.status = ST_OK;
    hit = shadow_count;
    for (k = shadow_count - 1; k >= 0; k--)
      if (shadow_nodes[k].id == id) hit = k;
    case (op)
      OP_CLEAR: shadow_count = 0;
      OP_INSERT: begin
        if (hit < shadow_count) r.status = ST_DUP;
        else if (shadow_count >= Depth) r.status = ST_FULL;
        else begin
          shadow_nodes[shadow_count] = '{id, ty, ext, px, py};
          hit = shadow_count;
          shadow_count++;
        end
      end
      OP_AUTO: begin
        top = '0;
        for (k = 0; k < shadow_count; k++)
          if ({1'b0, shadow_nodes[k].id} > top) top = {1'b0, shadow_nodes[k].id};
        top = top + 17'd1;
        if (top > {1'b0, MaxId}) r.status = ST_NOFREE;
        else if (shadow_count >= Depth) r.status = ST_FULL;
        else begin
          shadow_nodes[shadow_count] = '{top[15:0], 16'd0, 16'd0, px, py};
          hit = shadow_count;
          shadow_count++;
        end
      end
      OP_LOOKUP, OP_REMOVE, OP_CHID, OP_CHTYPE, OP_CHEXT, OP_CHPOS: begin
        if (hit >= shadow_count) r.status = ST_NOTFOUND;
        else if (op == OP_CHID) begin
          for (k = 0; k < shadow_count; k++)
            if (shadow_nodes[k].id == nid) r.status = ST_DUP;
          if (r.status == ST_OK) shadow_nodes[hit].id = nid;
        end else if (op == OP_CHTYPE) shadow_nodes[hit].ty = ty;
        else if (op == OP_CHEXT) shadow_nodes[hit].ext = ext;
        else if (op == OP_CHPOS) begin
          shadow_nodes[hit].x = px;
          shadow_nodes[hit].y = py;
        end
      end
      default: ;
    endcase
    // node fields only on success of a node operation
    if (r.status == ST_OK && op >= OP_LOOKUP && op <= OP_CHPOS) begin
      r.rid = shadow_nodes[hit].id;
      r.rty = shadow_nodes[hit].ty;
      r.rext = shadow_nodes[hit].ext;
      r.rx = shadow_nodes[hit].x;
      r.ry = shadow_nodes[hit].y;
      if (op == OP_REMOVE) begin
        for (k = hit; k + 1 < shadow_count; k++) shadow_nodes[k] = shadow_nodes[k + 1];
        shadow_count--;
      end
    end
    // bounding box after the operation
    if (shadow_count > 0) begin
      r.lx = shadow_nodes[0].x;
      r.hx = shadow_nodes[0].x;
      r.ly = shadow_nodes[0].y;
      r.hy = shadow_nodes[0].y;
      for (k = 1; k < shadow_count; k++) begin
        if ($signed(shadow_nodes[k].x) < $signed(r.lx)) r.lx = shadow_nodes[k].x;
        if ($signed(shadow_nodes[k].x) > $signed(r.hx)) r.hx = shadow_nodes[k].x;
        if ($signed(shadow_nodes[k].y) < $signed(r.ly)) r.ly = shadow_nodes[k].y;
        if ($signed(shadow_nodes[k].y) > $signed(r.hy)) r.hy = shadow_nodes[k].y;
      end
    end
    r.cnt = shadow_count[6:0];
    return r;
  endfunction

  // send one beat, with bursts and random gaps
  task automatic send_node_op(logic [3:0] op, logic [15:0] id, logic [15:0] nid,
      logic [15:0] ty, logic [15:0] ext, logic [31:0] px, logic [31:0] py);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= op;
    node_id_i <= id;
    new_id_i <= nid;
    node_type_i <= ty;
    ext_type_i <= ext;
    pos_x_i <= px;
    pos_y_i <= py;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_node_op(op, id, nid, ty, ext, px, py));
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
      default: return $urandom;
    endcase
  endfunction

  // ids mostly from a small pool so hits are common
  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'hFFFF;
      2: return 16'h0000;
      default: return 16'($urandom_range(1, 80));
    endcase
  endfunction

  task automatic send_random_op(int op_hi);
    send_node_op(4'($urandom_range(0, op_hi)), pick_id(), pick_id(), 16'($urandom),
                 16'($urandom), pick_coord(), pick_coord());
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_ops();
    send_node_op(OP_LOOKUP, 16'd5, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_AUTO, 16'd0, 16'd0, 16'd0, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_node_op(OP_INSERT, 16'hFFFF, 16'd0, 16'hFFFF, 16'h8000, 32'h7FFF_FFFF,
                 32'h8000_0000);
    send_node_op(OP_INSERT, 16'hFFFF, 16'd0, 16'd1, 16'h7FFF, 32'd0, 32'd0);
    send_node_op(OP_AUTO, 16'd0, 16'd0, 16'd0, 16'd0, 32'd1, 32'd1);
    send_node_op(OP_INSERT, 16'd0, 16'd0, 16'h1234, 16'hFFFF, 32'hFFFF_0000, 32'h0001_0000);
    send_node_op(OP_LOOKUP, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_CHID, 16'd1, 16'd1, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_CHID, 16'd1, 16'hFFFF, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_CHID, 16'd77, 16'd78, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_CHID, 16'hFFFF, 16'd9, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_CHTYPE, 16'd9, 16'd0, 16'hA5A5, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_CHEXT, 16'd9, 16'd0, 16'd0, 16'h8000, 32'd0, 32'd0);
    send_node_op(OP_CHPOS, 16'd9, 16'd0, 16'd0, 16'd0, 32'h8000_0000, 32'h8000_0000);
    send_node_op(OP_CHTYPE, 16'd99, 16'd0, 16'd1, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_CHEXT, 16'd99, 16'd0, 16'd0, 16'd1, 32'd0, 32'd0);
    send_node_op(OP_CHPOS, 16'd99, 16'd0, 16'd0, 16'd0, 32'd1, 32'd1);
    send_node_op(OP_REMOVE, 16'd99, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_REMOVE, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(4'd9, 16'd9, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
    send_node_op(OP_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_LOOKUP, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
  endtask

  // fill the table past full while the receiver holds off
  task automatic test_full_table();
    int n;
    hold_cycles = 3000;
    hold_off = 1'b1;
    for (n = 0; n < Depth + 3; n++)
      send_node_op(OP_AUTO, 16'd0, 16'd0, 16'd0, 16'd0, pick_coord(), pick_coord());
    send_node_op(OP_INSERT, 16'd500, 16'd0, 16'd1, 16'd1, 32'd0, 32'd0);
    send_node_op(OP_INSERT, 16'd1, 16'd0, 16'd1, 16'd1, 32'd0, 32'd0);
    send_node_op(OP_REMOVE, 16'd1, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_REMOVE, 16'd64, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_INSERT, 16'hFFFF, 16'd0, 16'd2, 16'd2, 32'd5, 32'd5);
    send_node_op(OP_AUTO, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    send_node_op(OP_INSERT, 16'hFFFF, 16'd0, 16'd2, 16'd2, 32'd5, 32'd5);
    for (n = 0; n < 30; n++) send_random_op(8);
    send_node_op(OP_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
  endtask

  // random operations, mostly with a populated table; clears are rare
  task automatic test_random_ops();
    int n;
    for (n = 0; n < 1800; n++) begin
      if ($urandom_range(0, 150) == 0)
        send_node_op(OP_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
      else if ($urandom_range(0, 40) == 0) send_random_op(15);
      else send_node_op(4'($urandom_range(1, 8)), pick_id(), pick_id(), 16'($urandom),
                        16'($urandom), pick_coord(), pick_coord());
    end
  endtask

  // receiver stall pattern and long hold-off
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      else hold_off <= 1'b0;
    end else begin
      out_stall_i <= (cycle_count % 600 < 300) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    node_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status exp %0d got %0d", want.status, status_o); error_count++; end
        if (result_id_o !== want.rid) begin
          $error("result_id exp %h got %h", want.rid, result_id_o); error_count++; end
        if (result_type_o !== want.rty) begin
          $error("result_type exp %h got %h", want.rty, result_type_o); error_count++; end
        if (result_ext_type_o !== want.rext) begin
          $error("result_ext_type exp %h got %h", want.rext, result_ext_type_o);
          error_count++; end
        if (result_x_o !== want.rx) begin
          $error("result_x exp %h got %h", want.rx, result_x_o); error_count++; end
        if (result_y_o !== want.ry) begin
          $error("result_y exp %h got %h", want.ry, result_y_o); error_count++; end
        if (min_x_o !== want.lx) begin
          $error("min_x exp %h got %h", want.lx, min_x_o); error_count++; end
        if (max_x_o !== want.hx) begin
          $error("max_x exp %h got %h", want.hx, max_x_o); error_count++; end
        if (min_y_o !== want.ly) begin
          $error("min_y exp %h got %h", want.ly, min_y_o); error_count++; end
        if (max_y_o !== want.hy) begin
          $error("max_y exp %h got %h", want.hy, max_y_o); error_count++; end
        if (entry_count_o !== want.cnt) begin
          $error("entry_count exp %0d got %0d", want.cnt, entry_count_o); error_count++; end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    operation_i = OP_CLEAR;
    node_id_i = '0;
    new_id_i = '0;
    node_type_i = '0;
    ext_type_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    hold_off = 1'b0;
    hold_cycles = 0;
    shadow_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_full_table();
    test_random_ops();
    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
